// ===== src/trtcm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths, register indexes and command/status structs for the two-rate meter.
package trtcm_pkg;

    localparam int TimeW    = 64;
    localparam int TokW     = 32;
    localparam int LenW     = 16;
    localparam int ColorW   = 2;
    localparam int DivSteps = TimeW;
    localparam int CntW     = $clog2(DivSteps);

    localparam int AddrW    = 6;
    localparam int DataW    = 64;
    localparam int RegShift = 3;
    localparam int RegIdxW  = AddrW - RegShift;

    typedef logic [TimeW-1:0]  t_time;
    typedef logic [TokW-1:0]   t_tok;
    typedef logic [LenW-1:0]   t_len;
    typedef logic [ColorW-1:0] t_color;

    localparam logic [RegIdxW-1:0] RegCommittedBurst  = 3'd0;
    localparam logic [RegIdxW-1:0] RegPeakBurst       = 3'd1;
    localparam logic [RegIdxW-1:0] RegCommittedPeriod = 3'd2;
    localparam logic [RegIdxW-1:0] RegCommittedRefill = 3'd3;
    localparam logic [RegIdxW-1:0] RegPeakPeriod      = 3'd4;
    localparam logic [RegIdxW-1:0] RegPeakRefill      = 3'd5;

    localparam t_color ColorGreen  = 2'd0;
    localparam t_color ColorYellow = 2'd1;
    localparam t_color ColorRed    = 2'd2;

    typedef struct packed {
        logic load;
        logic step;
        logic mul_lo;
        logic mul_hi;
        logic update;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_stat;

endpackage

// ===== src/trtcm_in_if.sv =====
`timescale 1ns / 1ps
// Packet input channel: valid/ready with arrival time and length.
interface trtcm_in_if;
    import trtcm_pkg::*;

    logic  valid;
    logic  ready;
    t_time arrival_time;
    t_len  packet_length;

    modport source (output valid, output arrival_time, output packet_length, input ready);
    modport sink   (input valid, input arrival_time, input packet_length, output ready);
endinterface

// ===== src/trtcm_out_if.sv =====
`timescale 1ns / 1ps
// Verdict output channel: valid/ready with the color.
interface trtcm_out_if;
    import trtcm_pkg::*;

    logic   valid;
    logic   ready;
    t_color color;

    modport source (output valid, output color, input ready);
    modport sink   (input valid, input color, output ready);
endinterface

// ===== src/trtcm_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine sequencing load, divide, multiply, refill and commit.
module trtcm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  trtcm_pkg::t_stat i_stat,
    output logic             o_in_ready,
    output trtcm_pkg::t_cmd  o_cmd
);
    import trtcm_pkg::*;

    localparam logic [2:0] StIdle   = 3'd0;
    localparam logic [2:0] StDiv    = 3'd1;
    localparam logic [2:0] StMulLo  = 3'd2;
    localparam logic [2:0] StMulHi  = 3'd3;
    localparam logic [2:0] StUpdate = 3'd4;
    localparam logic [2:0] StEmit   = 3'd5;

    logic [2:0]      r_state, n_state;
    logic [CntW-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            StIdle: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = StDiv;
                end
            end
            StDiv: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == CntW'(DivSteps - 1)) begin
                    n_state = StMulLo;
                end
            end
            StMulLo: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = StMulHi;
            end
            StMulHi: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = StUpdate;
            end
            StUpdate: begin
                o_cmd.update = 1'b1;
                n_state      = StEmit;
            end
            StEmit: begin
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = StIdle;
                end
            end
            default: begin
                n_state = StIdle;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StIdle;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ===== src/trtcm_bucket.sv =====
`timescale 1ns / 1ps
// One token bucket: radix-2 period divider, split refill multiplier, clamp and state.
module trtcm_bucket (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  trtcm_pkg::t_cmd  i_cmd,
    input  trtcm_pkg::t_time i_now,
    input  trtcm_pkg::t_time i_period,
    input  trtcm_pkg::t_tok  i_refill,
    input  trtcm_pkg::t_tok  i_burst,
    input  trtcm_pkg::t_tok  i_new_tokens,
    output trtcm_pkg::t_tok  o_level
);
    import trtcm_pkg::*;

    t_time             r_time;
    t_tok              r_tokens;
    t_time             r_rem;
    t_time             r_quo;
    logic [2*TokW-1:0] r_plo;
    logic              r_hi_nz;
    t_tok              r_level;

    logic              period_zero;
    logic [TimeW:0]    shifted;
    logic [TimeW:0]    trial;
    logic              ge;
    t_time             q_eff;
    t_tok              mul_a;
    logic [2*TokW-1:0] prod;
    logic [TokW:0]     sum;
    logic              sat;

    assign period_zero = (i_period == '0);
    assign shifted     = {r_rem, r_quo[TimeW-1]};
    assign trial       = shifted - {1'b0, i_period};
    assign ge          = (shifted >= {1'b0, i_period});

    assign q_eff = period_zero ? '0 : r_quo;
    assign mul_a = i_cmd.mul_hi ? q_eff[TimeW-1:TokW] : q_eff[TokW-1:0];
    assign prod  = mul_a * i_refill;

    assign sum = {1'b0, r_tokens} + {1'b0, r_plo[TokW-1:0]};
    assign sat = r_hi_nz || (r_plo[2*TokW-1:TokW] != '0) || (r_plo[TokW-1:0] >= i_burst)
                 || (sum > {1'b0, i_burst});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem <= '0;
            r_quo <= i_now - r_time;
        end else if (i_cmd.step) begin
            r_rem <= ge ? trial[TimeW-1:0] : shifted[TimeW-1:0];
            r_quo <= {r_quo[TimeW-2:0], ge};
        end
        if (i_cmd.mul_lo) begin
            r_plo <= prod;
        end
        if (i_cmd.mul_hi) begin
            r_hi_nz <= (prod != '0);
        end
        if (i_cmd.update) begin
            r_level <= sat ? i_burst : sum[TokW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time   <= '0;
            r_tokens <= '0;
        end else begin
            if (i_cmd.update && !period_zero) begin
                r_time <= i_now - r_rem;
            end
            if (i_cmd.commit) begin
                r_tokens <= i_new_tokens;
            end
        end
    end

    assign o_level = r_level;

endmodule

// ===== src/trtcm_dp.sv =====
`timescale 1ns / 1ps
// Datapath: packet capture, both buckets, color decision, debit and output register.
module trtcm_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  trtcm_pkg::t_cmd   i_cmd,
    output trtcm_pkg::t_stat  o_stat,
    input  trtcm_pkg::t_time  i_arrival_time,
    input  trtcm_pkg::t_len   i_packet_length,
    input  trtcm_pkg::t_tok   i_committed_burst,
    input  trtcm_pkg::t_tok   i_peak_burst,
    input  trtcm_pkg::t_time  i_committed_period,
    input  trtcm_pkg::t_tok   i_committed_refill,
    input  trtcm_pkg::t_time  i_peak_period,
    input  trtcm_pkg::t_tok   i_peak_refill,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output trtcm_pkg::t_color o_color
);
    import trtcm_pkg::*;

    t_time  r_now;
    t_len   r_len;
    logic   r_out_valid;
    t_color r_color;

    t_time  now;
    t_tok   c_level, p_level;
    t_tok   len_ext;
    t_tok   n_c_tok, n_p_tok;
    t_color n_color;

    assign now     = i_cmd.load ? i_arrival_time : r_now;
    assign len_ext = {{(TokW - LenW){1'b0}}, r_len};

    trtcm_bucket u_cbkt (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (i_cmd),
        .i_now        (now),
        .i_period     (i_committed_period),
        .i_refill     (i_committed_refill),
        .i_burst      (i_committed_burst),
        .i_new_tokens (n_c_tok),
        .o_level      (c_level)
    );

    trtcm_bucket u_pbkt (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (i_cmd),
        .i_now        (now),
        .i_period     (i_peak_period),
        .i_refill     (i_peak_refill),
        .i_burst      (i_peak_burst),
        .i_new_tokens (n_p_tok),
        .o_level      (p_level)
    );

    always_comb begin
        n_c_tok = c_level;
        n_p_tok = p_level;
        if (p_level < len_ext) begin
            n_color = ColorRed;
        end else if (c_level < len_ext) begin
            n_color = ColorYellow;
            n_p_tok = p_level - len_ext;
        end else begin
            n_color = ColorGreen;
            n_c_tok = c_level - len_ext;
            n_p_tok = p_level - len_ext;
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_now <= i_arrival_time;
            r_len <= i_packet_length;
        end
        if (i_cmd.commit) begin
            r_color <= n_color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_color     = r_color;

    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> o_stat.out_free)
        else $error("commit while output register is held");

    a_valid_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_cmd.commit))
        else $error("output valid without commit");

    a_color_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_color == ColorGreen || r_color == ColorYellow
                         || r_color == ColorRed))
        else $error("illegal color code");

    a_level_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.update) |-> (c_level <= i_committed_burst && p_level <= i_peak_burst))
        else $error("refilled level above burst size");

endmodule

// ===== src/two_rate_three_color_meter.sv =====
`timescale 1ns / 1ps
// Top level: register port, packet and verdict channels, controller and datapath.
//
//   channel   kind           payload
//   i_pkt     valid/ready    arrival_time[63:0], packet_length[15:0]
//   o_res     valid/ready    color[1:0]
//   apb       psel/penable   paddr[5:0], pwdata/prdata[63:0], register i at 8*i
//
// One packet at a time: after an accept the verdict reaches the output register through the
// 64 radix-2 steps of the period dividers (both buckets run side by side), two 32x32 refill
// multiplies, a clamp step and a debit step; no new packet is accepted in between.
// Sync active-low reset: buckets, times, bursts, refills, output valid to 0; periods to 1.
// A held verdict stalls the debit cycle; the next packet is taken once it commits.
module two_rate_three_color_meter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [trtcm_pkg::AddrW-1:0] paddr,
    input  logic [trtcm_pkg::DataW-1:0] pwdata,
    output logic [trtcm_pkg::DataW-1:0] prdata,
    output logic                        pready,
    trtcm_in_if.sink                    i_pkt,
    trtcm_out_if.source                 o_res
);
    import trtcm_pkg::*;

    t_tok  r_cbr, r_pbr, r_cref, r_pref;
    t_time r_cper, r_pper;

    logic [RegIdxW-1:0] idx;
    logic               wr;
    t_cmd               cmd;
    t_stat              stat;
    logic               in_ready;

    assign idx    = paddr[AddrW-1:RegShift];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cbr  <= '0;
            r_pbr  <= '0;
            r_cper <= TimeW'(1);
            r_cref <= '0;
            r_pper <= TimeW'(1);
            r_pref <= '0;
        end else if (wr) begin
            case (idx)
                RegCommittedBurst:  r_cbr  <= pwdata[TokW-1:0];
                RegPeakBurst:       r_pbr  <= pwdata[TokW-1:0];
                RegCommittedPeriod: r_cper <= pwdata[TimeW-1:0];
                RegCommittedRefill: r_cref <= pwdata[TokW-1:0];
                RegPeakPeriod:      r_pper <= pwdata[TimeW-1:0];
                RegPeakRefill:      r_pref <= pwdata[TokW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (idx)
            RegCommittedBurst:  prdata = DataW'(r_cbr);
            RegPeakBurst:       prdata = DataW'(r_pbr);
            RegCommittedPeriod: prdata = DataW'(r_cper);
            RegCommittedRefill: prdata = DataW'(r_cref);
            RegPeakPeriod:      prdata = DataW'(r_pper);
            RegPeakRefill:      prdata = DataW'(r_pref);
            default:            prdata = '0;
        endcase
    end

    trtcm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pkt.valid),
        .i_stat     (stat),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    trtcm_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .i_arrival_time     (i_pkt.arrival_time),
        .i_packet_length    (i_pkt.packet_length),
        .i_committed_burst  (r_cbr),
        .i_peak_burst       (r_pbr),
        .i_committed_period (r_cper),
        .i_committed_refill (r_cref),
        .i_peak_period      (r_pper),
        .i_peak_refill      (r_pref),
        .i_out_ready        (o_res.ready),
        .o_out_valid        (o_res.valid),
        .o_color            (o_res.color)
    );

    assign i_pkt.ready = in_ready;

endmodule
